// File: rtl/core/pps_pkg.sv
// package: shared constants, request/result types and table record for the scheduler
`default_nettype none
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int TIME_W = 24;
  localparam int PRIO_W = 8;
  localparam int BRST_W = 16;
  localparam int ID_W   = 5;
  localparam int SUM_W  = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [BRST_W-1:0] PROG_MAX = {BRST_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio_value;
    logic [BRST_W-1:0] burst;
  } pps_in_t;

  typedef struct packed {
    logic              idle;
    logic [ID_W-1:0]   ran_id;
    logic              finished_now;
    logic [TIME_W-1:0] start_at;
    logic [TIME_W-1:0] completion_at;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [SUM_W-1:0]  sum_turnaround;
    logic [SUM_W-1:0]  sum_waiting;
  } pps_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    logic [BRST_W-1:0] burst;
    logic [BRST_W-1:0] progress;
    logic [TIME_W-1:0] start;
  } pps_rec_t;

  localparam int REC_W = $bits(pps_rec_t);

  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             done;
  } pps_sel_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pick;
    pps_rec_t         rec;
  } pps_sel_res_t;

endpackage
`default_nettype wire

// File: rtl/core/pps_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module pps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pps_sel.sv
// running minimum-priority selector fed one table entry per cycle
`default_nettype none
module pps_sel
  import pps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pps_sel_ctl_t      ctl,
  input  wire pps_rec_t          rec,
  input  wire logic [TIME_W-1:0] now,
  output pps_sel_res_t           res
);

  logic              found_r;
  logic [PRIO_W:0]   best_r;
  logic [IDX_W-1:0]  pick_r;
  pps_rec_t          rec_r;
  logic              take;

  assign take = ctl.vld && !ctl.done && (rec.arrival <= now) &&
                ({1'b0, rec.prio} < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      best_r  <= {1'b1, {PRIO_W{1'b0}}};
    end else if (ctl.clr) begin
      found_r <= 1'b0;
      best_r  <= {1'b1, {PRIO_W{1'b0}}};
    end else if (take) begin
      found_r <= 1'b1;
      best_r  <= {1'b0, rec.prio};
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clr) begin
      pick_r <= ctl.idx;
      rec_r  <= rec;
    end
  end

  assign res.found = found_r;
  assign res.pick  = pick_r;
  assign res.rec   = rec_r;

endmodule
`default_nettype wire

// File: rtl/core/preemptive_priority_scheduler.sv
// top level: process table, tick sequencer and result register
// A request with op = load appends a process to the table (ignored when the
// table is full); a request with op = tick keeps busy high while it works: one
// ram read per loaded entry to find the lowest priority value among arrived,
// unfinished entries, a step to drain the read, one to work out progress and
// times, one to write the chosen entry back. The result then shows on out_data
// with out_valid high for exactly one cycle, as busy drops; it must be taken
// then, since there is no way to hold it. Table storage starts undefined and
// only loaded entries are read; reset clears counts, flags, time and totals.
`default_nettype none
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire pps_in_t in_data,
  output logic         busy,
  output logic         out_valid,
  output pps_out_t     out_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVAL, S_FIN} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  entry_count_r;
  logic [CNT_W-1:0]  done_count_r;
  logic [CNT_W-1:0]  done_count_nxt;
  logic [TIME_W-1:0] now_r;
  logic [SUM_W-1:0]  total_tat_r;
  logic [SUM_W-1:0]  total_wait_r;
  logic              done_r    [MAX_PROCS];
  logic              started_r [MAX_PROCS];

  logic [CNT_W-1:0]  rd_cnt_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;

  logic [BRST_W-1:0] prog_r;
  logic [TIME_W-1:0] st_r;
  logic [TIME_W-1:0] tat_r;
  logic [TIME_W-1:0] next_r;
  logic              fin_r;

  logic              out_valid_r;
  pps_out_t          out_data_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  pps_rec_t          ram_wdata;
  logic              ram_re;
  pps_rec_t          ram_rdata;

  pps_sel_ctl_t      sel_ctl;
  pps_sel_res_t      sel_res;

  logic              load_go;
  logic              tick_go;
  logic [BRST_W-1:0] prog_nxt;
  logic [TIME_W-1:0] tat_nxt;
  logic [TIME_W-1:0] wt_nxt;
  logic [SUM_W:0]    tat_sum;
  logic [SUM_W:0]    wait_sum;
  logic [IDX_W:0]    id_calc;

  assign load_go = (state_r == S_IDLE) && start && (in_data.op == OP_LOAD) &&
                   (entry_count_r < CNT_W'(MAX_PROCS));
  assign tick_go = (state_r == S_IDLE) && start && (in_data.op == OP_TICK);

  pps_ram #(
    .DEPTH(MAX_PROCS),
    .WIDTH(REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_re = (state_r == S_SCAN) && (rd_cnt_r < entry_count_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_count_r[IDX_W-1:0];
    ram_wdata = '0;
    if (load_go) begin
      ram_we             = 1'b1;
      ram_wdata.arrival  = in_data.arrival;
      ram_wdata.prio     = in_data.prio_value;
      ram_wdata.burst    = in_data.burst;
    end else if ((state_r == S_FIN) && sel_res.found) begin
      ram_we             = 1'b1;
      ram_waddr          = sel_res.pick;
      ram_wdata          = sel_res.rec;
      ram_wdata.progress = prog_r;
      ram_wdata.start    = st_r;
    end
  end

  assign sel_ctl.clr  = tick_go;
  assign sel_ctl.vld  = rd_vld_r;
  assign sel_ctl.idx  = rd_idx_r;
  assign sel_ctl.done = done_r[rd_idx_r];

  pps_sel u_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sel_ctl),
    .rec   (ram_rdata),
    .now   (now_r),
    .res   (sel_res)
  );

  // evaluation of the chosen entry
  assign prog_nxt = (sel_res.rec.progress < PROG_MAX) ?
                    sel_res.rec.progress + BRST_W'(1) : sel_res.rec.progress;
  assign tat_nxt  = ((now_r == TIME_MAX) ? now_r : now_r + TIME_W'(1)) -
                    sel_res.rec.arrival;

  // completion figures
  assign wt_nxt   = (tat_r >= TIME_W'(sel_res.rec.burst)) ?
                    tat_r - TIME_W'(sel_res.rec.burst) : '0;
  assign tat_sum  = {1'b0, total_tat_r} + (SUM_W + 1)'(tat_r);
  assign wait_sum = {1'b0, total_wait_r} + (SUM_W + 1)'(wt_nxt);
  assign done_count_nxt = done_count_r + CNT_W'(fin_r);
  assign id_calc  = {1'b0, sel_res.pick} + (IDX_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      done_count_r  <= '0;
      now_r         <= '0;
      total_tat_r   <= '0;
      total_wait_r  <= '0;
      rd_cnt_r      <= '0;
      rd_vld_r      <= 1'b0;
      fin_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        done_r[i]    <= 1'b0;
        started_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (load_go) begin
            done_r[entry_count_r[IDX_W-1:0]]    <= 1'b0;
            started_r[entry_count_r[IDX_W-1:0]] <= 1'b0;
            entry_count_r <= entry_count_r + CNT_W'(1);
          end
          if (tick_go) begin
            rd_cnt_r <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_cnt_r < entry_count_r) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= rd_cnt_r[IDX_W-1:0];
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end else begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          prog_r  <= prog_nxt;
          st_r    <= started_r[sel_res.pick] ? sel_res.rec.start : now_r;
          tat_r   <= tat_nxt;
          next_r  <= (now_r == TIME_MAX) ? now_r : now_r + TIME_W'(1);
          fin_r   <= sel_res.found && (prog_nxt >= sel_res.rec.burst);
          state_r <= S_FIN;
        end
        S_FIN: begin
          now_r <= next_r;
          if (sel_res.found) begin
            started_r[sel_res.pick] <= 1'b1;
          end
          if (fin_r) begin
            done_r[sel_res.pick] <= 1'b1;
            done_count_r <= done_count_nxt;
            total_tat_r  <= tat_sum[SUM_W] ? SUM_MAX : tat_sum[SUM_W-1:0];
            total_wait_r <= wait_sum[SUM_W] ? SUM_MAX : wait_sum[SUM_W-1:0];
          end
          out_valid_r                 <= 1'b1;
          out_data_r.idle             <= !sel_res.found;
          out_data_r.ran_id           <= sel_res.found ? ID_W'(id_calc) : '0;
          out_data_r.finished_now     <= fin_r;
          out_data_r.start_at         <= fin_r ? st_r : '0;
          out_data_r.completion_at    <= fin_r ? next_r : '0;
          out_data_r.turnaround       <= fin_r ? tat_r : '0;
          out_data_r.waiting          <= fin_r ? wt_nxt : '0;
          out_data_r.all_done         <= (done_count_nxt >= entry_count_r);
          out_data_r.sum_turnaround   <= fin_r ?
              (tat_sum[SUM_W] ? SUM_MAX : tat_sum[SUM_W-1:0]) : total_tat_r;
          out_data_r.sum_waiting      <= fin_r ?
              (wait_sum[SUM_W] ? SUM_MAX : wait_sum[SUM_W-1:0]) : total_wait_r;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/core/pps_chk.sv
// port-level checker for the scheduler and its bind
`default_nettype none
module pps_chk
  import pps_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire pps_in_t  in_data,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire pps_out_t out_data
);

  // a result only shows as the block goes free
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a tick request keeps the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.op == OP_TICK)) |=> busy)
    else $error("tick request did not start work");

  // a load request gives no result and frees at once
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.op == OP_LOAD)) |=> (!busy && !out_valid))
    else $error("load request produced a result or stalled");

  // an idle tick names no process and finishes nothing
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.idle) |-> ((out_data.ran_id == '0) &&
                                      !out_data.finished_now))
    else $error("idle tick reports a process");

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_data   (in_data),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
